[rtl/core/adjslot_pkg.sv]
// Shared types and constants for the adjacency slot store.
package adjslot_pkg;

  localparam int NUM_VERTICES = 1024;
  localparam int MAX_DEGREE   = 16;

  localparam int VERTEX_W = 10;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;
  localparam int DEGREE_W = 5;

  localparam int VADDR_W  = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int NB_DEPTH = NUM_VERTICES * MAX_DEGREE;
  localparam int NADDR_W  = (NB_DEPTH > 1) ? $clog2(NB_DEPTH) : 1;
  localparam int COUNT_W  = $clog2(MAX_DEGREE + 1);

  typedef logic [1:0] action_t;
  localparam action_t ACT_APPEND_DIR   = 2'd0;
  localparam action_t ACT_APPEND_UNDIR = 2'd1;
  localparam action_t ACT_ERASE_DIR    = 2'd2;
  localparam action_t ACT_READ_SLOT    = 2'd3;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STATUS_OK         = 3'd0;
  localparam status_t STATUS_BAD_VERTEX = 3'd1;
  localparam status_t STATUS_FULL       = 3'd2;
  localparam status_t STATUS_NOT_FOUND  = 3'd3;
  localparam status_t STATUS_BAD_SLOT   = 3'd4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEC_A,
    ST_DEC_B,
    ST_WR_B,
    ST_GET_N,
    ST_SEARCH,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage

[rtl/core/adjacency_slot_store.sv]
// Adjacency slot store: per-vertex neighbor lists of fixed capacity with entry counts.
//
// Each vertex owns MAX_DEGREE slots in a single-port-read, single-port-write neighbor
// memory, and its entry count lives in a second memory of NUM_VERTICES words. After
// reset the block first zeroes every entry count, one per cycle, and holds off
// requests until that is done. One request is worked at a time and yields one
// response. Both the search and the left shift of an erase move through the list
// at one neighbor-memory read per cycle. A new request is taken as soon as the
// previous response sits in the output register, even if it has not been
// collected yet.
module adjacency_slot_store
  import adjslot_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [1:0]          action,
  input  logic [VERTEX_W-1:0] first_vertex,
  input  logic [VERTEX_W-1:0] second_vertex,
  input  logic [SLOT_W-1:0]   slot_index,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [DEGREE_W-1:0] degree,
  output logic [VERTEX_W-1:0] neighbor
);

  // Memories.
  logic [VERTEX_W-1:0] nb_mem  [NB_DEPTH];
  logic [COUNT_W-1:0]  deg_mem [NUM_VERTICES];

  logic                nb_we;
  logic [NADDR_W-1:0]  nb_wa, nb_ra;
  logic [VERTEX_W-1:0] nb_wd, nb_q;
  logic                deg_we;
  logic [VADDR_W-1:0]  deg_wa, deg_ra;
  logic [COUNT_W-1:0]  deg_wd, deg_q;

  always_ff @(posedge clk) begin
    if (nb_we) begin
      nb_mem[nb_wa] <= nb_wd;
    end
    nb_q <= nb_mem[nb_ra];
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
    end
    deg_q <= deg_mem[deg_ra];
  end

  // Control and working registers.
  state_t                state, state_next;
  action_t               act, act_next;
  logic [VERTEX_W-1:0]   va, va_next, vb, vb_next;
  logic [SLOT_W-1:0]     slot, slot_next;
  logic [COUNT_W-1:0]    cnt_a, cnt_a_next, cnt_b, cnt_b_next;
  logic [COUNT_W-1:0]    rd_idx, rd_idx_next, wr_idx, wr_idx_next, cmp_idx, cmp_idx_next;
  logic                  pend, pend_next;
  logic [VADDR_W-1:0]    clr_addr, clr_addr_next;
  status_t               res_status, res_status_next;
  logic [COUNT_W-1:0]    res_degree, res_degree_next;
  logic [VERTEX_W-1:0]   res_neighbor, res_neighbor_next;
  logic                  rsp_valid_next;
  logic [STATUS_W-1:0]   status_next;
  logic [DEGREE_W-1:0]   degree_next;
  logic [VERTEX_W-1:0]   neighbor_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      pend      <= pend_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    act          <= act_next;
    va           <= va_next;
    vb           <= vb_next;
    slot         <= slot_next;
    cnt_a        <= cnt_a_next;
    cnt_b        <= cnt_b_next;
    rd_idx       <= rd_idx_next;
    wr_idx       <= wr_idx_next;
    cmp_idx      <= cmp_idx_next;
    res_status   <= res_status_next;
    res_degree   <= res_degree_next;
    res_neighbor <= res_neighbor_next;
    status       <= status_next;
    degree       <= degree_next;
    neighbor     <= neighbor_next;
  end

  logic [NADDR_W-1:0] base_a, base_b;
  logic               a_in_bad, b_bad, same, issue;

  assign base_a   = NADDR_W'(va) * NADDR_W'(MAX_DEGREE);
  assign base_b   = NADDR_W'(vb) * NADDR_W'(MAX_DEGREE);
  assign a_in_bad = 32'(first_vertex) >= NUM_VERTICES;
  assign b_bad    = 32'(vb) >= NUM_VERTICES;
  assign same     = (va == vb);
  assign issue    = (rd_idx < cnt_a);

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next        = state;
    act_next          = act;
    va_next           = va;
    vb_next           = vb;
    slot_next         = slot;
    cnt_a_next        = cnt_a;
    cnt_b_next        = cnt_b;
    rd_idx_next       = rd_idx;
    wr_idx_next       = wr_idx;
    cmp_idx_next      = cmp_idx;
    pend_next         = pend;
    clr_addr_next     = clr_addr;
    res_status_next   = res_status;
    res_degree_next   = res_degree;
    res_neighbor_next = res_neighbor;
    status_next       = status;
    degree_next       = degree;
    neighbor_next     = neighbor;
    rsp_valid_next    = rsp_valid && rsp_stall;

    nb_we  = 1'b0;
    nb_wa  = base_a + NADDR_W'(wr_idx);
    nb_wd  = nb_q;
    nb_ra  = base_a + NADDR_W'(rd_idx);
    deg_we = 1'b0;
    deg_wa = VADDR_W'(va);
    deg_wd = '0;
    deg_ra = VADDR_W'(va);

    unique case (state)
      ST_CLEAR: begin
        deg_we        = 1'b1;
        deg_wa        = clr_addr;
        deg_wd        = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == VADDR_W'(NUM_VERTICES - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        deg_ra = VADDR_W'(first_vertex);
        if (req_valid) begin
          act_next          = action;
          va_next           = first_vertex;
          vb_next           = second_vertex;
          slot_next         = slot_index;
          res_neighbor_next = '0;
          res_status_next   = STATUS_OK;
          if (a_in_bad) begin
            res_status_next = STATUS_BAD_VERTEX;
            res_degree_next = '0;
            state_next      = ST_DONE;
          end else begin
            state_next = ST_DEC_A;
          end
        end
      end

      ST_DEC_A: begin
        cnt_a_next      = deg_q;
        res_degree_next = deg_q;
        deg_ra          = VADDR_W'(vb);
        nb_ra           = base_a + NADDR_W'(slot);
        rd_idx_next     = '0;
        pend_next       = 1'b0;
        if (b_bad && act != ACT_READ_SLOT) begin
          res_status_next = STATUS_BAD_VERTEX;
          state_next      = ST_DONE;
        end else begin
          unique case (act)
            ACT_APPEND_DIR: begin
              state_next = ST_DONE;
              if (32'(deg_q) >= MAX_DEGREE) begin
                res_status_next = STATUS_FULL;
              end else begin
                nb_we           = 1'b1;
                nb_wa           = base_a + NADDR_W'(deg_q);
                nb_wd           = vb;
                deg_we          = 1'b1;
                deg_wd          = deg_q + 1'b1;
                res_degree_next = deg_q + 1'b1;
              end
            end
            ACT_APPEND_UNDIR: begin
              state_next = ST_DEC_B;
            end
            ACT_ERASE_DIR: begin
              if (deg_q == '0) begin
                res_status_next = STATUS_NOT_FOUND;
                state_next      = ST_DONE;
              end else begin
                state_next = ST_SEARCH;
              end
            end
            default: begin
              // Slot read; the neighbor memory read is issued in this cycle.
              if (32'(slot) >= 32'(deg_q)) begin
                res_status_next = STATUS_BAD_SLOT;
                state_next      = ST_DONE;
              end else begin
                state_next = ST_GET_N;
              end
            end
          endcase
        end
      end

      ST_DEC_B: begin
        if ((same && (32'(cnt_a) + 2 > MAX_DEGREE)) ||
            (!same && ((32'(cnt_a) + 1 > MAX_DEGREE) || (32'(deg_q) >= MAX_DEGREE)))) begin
          res_status_next = STATUS_FULL;
          state_next      = ST_DONE;
        end else begin
          nb_we      = 1'b1;
          nb_wa      = base_a + NADDR_W'(cnt_a);
          nb_wd      = vb;
          deg_we     = 1'b1;
          deg_wd     = cnt_a + 1'b1;
          // A self loop places its second entry right after the first one.
          cnt_b_next = same ? (cnt_a + 1'b1) : deg_q;
          res_degree_next = same ? COUNT_W'(32'(cnt_a) + 2) : (cnt_a + 1'b1);
          state_next = ST_WR_B;
        end
      end

      ST_WR_B: begin
        nb_we      = 1'b1;
        nb_wa      = base_b + NADDR_W'(cnt_b);
        nb_wd      = va;
        deg_we     = 1'b1;
        deg_wa     = VADDR_W'(vb);
        deg_wd     = cnt_b + 1'b1;
        state_next = ST_DONE;
      end

      ST_GET_N: begin
        res_neighbor_next = nb_q;
        state_next        = ST_DONE;
      end

      ST_SEARCH: begin
        // Reads stream one per cycle; each read word is compared in the cycle after its read.
        if (pend && nb_q == vb) begin
          rd_idx_next = cmp_idx + 1'b1;
          wr_idx_next = cmp_idx;
          pend_next   = 1'b0;
          state_next  = ST_SHIFT;
        end else if (pend && cmp_idx == cnt_a - 1'b1) begin
          res_status_next = STATUS_NOT_FOUND;
          state_next      = ST_DONE;
        end else begin
          pend_next    = issue;
          cmp_idx_next = rd_idx;
          if (issue) begin
            rd_idx_next = rd_idx + 1'b1;
          end
        end
      end

      ST_SHIFT: begin
        // Each entry read is written back one slot lower in the next cycle.
        if (pend) begin
          nb_we       = 1'b1;
          wr_idx_next = wr_idx + 1'b1;
        end
        if (!issue && !pend) begin
          deg_we          = 1'b1;
          deg_wd          = cnt_a - 1'b1;
          res_degree_next = cnt_a - 1'b1;
          state_next      = ST_DONE;
        end else begin
          pend_next = issue;
          if (issue) begin
            rd_idx_next = rd_idx + 1'b1;
          end
        end
      end

      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next = 1'b1;
          status_next    = res_status;
          degree_next    = DEGREE_W'(res_degree);
          neighbor_next  = res_neighbor;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[dv/testbench.sv]
// Self-checking testbench for the adjacency slot store: directed table, then random list traffic.
`timescale 1ns / 1ps

module testbench;
  import adjslot_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_OPS   = 200;
  localparam int NUM_ROWS    = 21;
  localparam int DRAIN_WAIT  = 40;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    action_t             act;
    logic [VERTEX_W-1:0] first;
    logic [VERTEX_W-1:0] second;
    logic [SLOT_W-1:0]   slot;
  } list_op_t;

  typedef struct packed {
    status_t             status;
    logic [DEGREE_W-1:0] degree;
    logic [VERTEX_W-1:0] neighbor;
  } list_reply_t;

  typedef struct {
    action_t act;
    int      first;
    int      second;
    int      slot;
    int      reps;
    bit      typed;
    status_t status;
    int      degree;
    int      neighbor;
  } table_row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic [1:0]          action = '0;
  logic [VERTEX_W-1:0] first_vertex = '0;
  logic [VERTEX_W-1:0] second_vertex = '0;
  logic [SLOT_W-1:0]   slot_index = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [DEGREE_W-1:0] degree;
  logic [VERTEX_W-1:0] neighbor;

  // Shadow copy of the neighbor lists and their entry counts.
  logic [VERTEX_W-1:0] shadow_slots [NUM_VERTICES*MAX_DEGREE];
  int                  shadow_count [NUM_VERTICES];

  list_reply_t awaited_replies [$];
  table_row_t  dir_rows [NUM_ROWS];
  int          vpool [4];
  int          fails = 0;
  bit          quiet = 1'b0;
  bit          hold_request = 1'b0;

  adjacency_slot_store u_top (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .action       (action),
    .first_vertex (first_vertex),
    .second_vertex(second_vertex),
    .slot_index   (slot_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .degree       (degree),
    .neighbor     (neighbor)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  function automatic void push_entry(int v, int nb);
    shadow_slots[v*MAX_DEGREE + shadow_count[v]] = nb[VERTEX_W-1:0];
    shadow_count[v]++;
  endfunction

  // Applies one transaction to the shadow lists and returns the reply it must produce.
  function automatic list_reply_t update_lists(list_op_t op);
    list_reply_t rep;
    int a;
    int b;
    int n;
    int pos;
    int need;
    a = int'(op.first);
    b = int'(op.second);
    rep = '{status: STATUS_OK, degree: '0, neighbor: '0};
    // At the default size every 10-bit vertex is in range, so this never fires.
    if (a >= NUM_VERTICES || (op.act != ACT_READ_SLOT && b >= NUM_VERTICES)) begin
      rep.status = STATUS_BAD_VERTEX;
    end else begin
      case (op.act)
        ACT_APPEND_DIR: begin
          if (shadow_count[a] >= MAX_DEGREE) rep.status = STATUS_FULL;
          else push_entry(a, b);
        end
        ACT_APPEND_UNDIR: begin
          need = (a == b) ? 2 : 1;
          if (shadow_count[a] + need > MAX_DEGREE || shadow_count[b] >= MAX_DEGREE) begin
            rep.status = STATUS_FULL;
          end else begin
            push_entry(a, b);
            push_entry(b, a);
          end
        end
        ACT_ERASE_DIR: begin
          n = shadow_count[a];
          pos = n;
          for (int i = 0; i < n; i++) begin
            if (pos == n && shadow_slots[a*MAX_DEGREE + i] == b[VERTEX_W-1:0]) pos = i;
          end
          if (pos == n) begin
            rep.status = STATUS_NOT_FOUND;
          end else begin
            for (int i = pos + 1; i < n; i++)
              shadow_slots[a*MAX_DEGREE + i - 1] = shadow_slots[a*MAX_DEGREE + i];
            shadow_count[a] = n - 1;
          end
        end
        default: begin
          if (op.slot >= shadow_count[a]) rep.status = STATUS_BAD_SLOT;
          else rep.neighbor = shadow_slots[a*MAX_DEGREE + op.slot];
        end
      endcase
    end
    if (a < NUM_VERTICES) rep.degree = shadow_count[a][DEGREE_W-1:0];
    return rep;
  endfunction

  task automatic send_op(list_op_t op, bit typed, list_reply_t want);
    list_reply_t model_rep;
    req_valid     <= 1'b1;
    action        <= op.act;
    first_vertex  <= op.first;
    second_vertex <= op.second;
    slot_index    <= op.slot;
    do @(posedge clk); while (req_stall);
    model_rep = update_lists(op);
    if (typed) model_rep = want;
    awaited_replies = {awaited_replies, model_rep};
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic int pick_vertex();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, NUM_VERTICES - 1);
    return vpool[$urandom_range(0, 3)];
  endfunction

  // Mostly traffic on a small set of vertices so that lists fill, erases hit and shift.
  function automatic list_op_t random_op();
    list_op_t op;
    int sel;
    int a;
    int n;
    sel = $urandom_range(0, 99);
    a = pick_vertex();
    n = shadow_count[a];
    op.first  = VERTEX_W'(a);
    op.second = VERTEX_W'(pick_vertex());
    op.slot   = SLOT_W'($urandom_range(0, 15));
    if (sel < 30) op.act = ACT_APPEND_DIR;
    else if (sel < 50) op.act = ACT_APPEND_UNDIR;
    else if (sel < 75) op.act = ACT_ERASE_DIR;
    else op.act = ACT_READ_SLOT;
    if (op.act == ACT_ERASE_DIR && n > 0 && $urandom_range(0, 3) != 0)
      op.second = shadow_slots[a*MAX_DEGREE + $urandom_range(0, n - 1)];
    if (op.act == ACT_READ_SLOT && n > 0 && $urandom_range(0, 9) < 7)
      op.slot = SLOT_W'($urandom_range(0, n - 1));
    return op;
  endfunction

  task automatic wait_drained();
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  // Reply side: checks each transaction and stalls in random bursts or one long hold.
  initial begin
    list_reply_t want;
    int hold_left;
    int burst_left;
    hold_left = 0;
    burst_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (awaited_replies.size() == 0) begin
          $error("unexpected reply: status %0d degree %0d neighbor %0d", status, degree,
                 neighbor);
          fails++;
        end else begin
          want = awaited_replies.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fails++;
          end
          if (degree !== want.degree) begin
            $error("degree: expected %0d, got %0d", want.degree, degree);
            fails++;
          end
          if (neighbor !== want.neighbor) begin
            $error("neighbor: expected %0d, got %0d", want.neighbor, neighbor);
            fails++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(0, 3);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    list_op_t    op;
    list_reply_t want;
    for (int v = 0; v < NUM_VERTICES; v++) shadow_count[v] = 0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;

    // Vertex 7 gets seven self loops (fourteen entries) before the capacity rows.
    dir_rows = '{
      '{ACT_READ_SLOT,    0,    0,    15, 1, 1, STATUS_BAD_SLOT,  0,  0},
      '{ACT_APPEND_DIR,   0,    1023, 0,  1, 1, STATUS_OK,        1,  0},
      '{ACT_READ_SLOT,    0,    0,    0,  1, 1, STATUS_OK,        1,  1023},
      '{ACT_ERASE_DIR,    0,    5,    0,  1, 1, STATUS_NOT_FOUND, 1,  0},
      '{ACT_ERASE_DIR,    0,    1023, 0,  1, 1, STATUS_OK,        0,  0},
      '{ACT_APPEND_UNDIR, 1023, 0,    0,  1, 1, STATUS_OK,        1,  0},
      '{ACT_READ_SLOT,    0,    0,    0,  1, 1, STATUS_OK,        1,  1023},
      '{ACT_READ_SLOT,    1023, 1023, 0,  1, 1, STATUS_OK,        1,  0},
      '{ACT_APPEND_UNDIR, 7,    7,    0,  7, 0, STATUS_OK,        0,  0},
      '{ACT_APPEND_DIR,   7,    3,    0,  1, 1, STATUS_OK,        15, 0},
      '{ACT_APPEND_UNDIR, 7,    7,    0,  1, 1, STATUS_FULL,      15, 0},
      '{ACT_APPEND_UNDIR, 7,    8,    0,  1, 1, STATUS_OK,        16, 0},
      '{ACT_APPEND_DIR,   7,    0,    0,  1, 1, STATUS_FULL,      16, 0},
      '{ACT_APPEND_UNDIR, 8,    7,    0,  1, 1, STATUS_FULL,      1,  0},
      '{ACT_READ_SLOT,    7,    0,    15, 1, 1, STATUS_OK,        16, 8},
      '{ACT_READ_SLOT,    7,    0,    14, 1, 1, STATUS_OK,        16, 3},
      '{ACT_ERASE_DIR,    7,    7,    0,  1, 1, STATUS_OK,        15, 0},
      '{ACT_READ_SLOT,    7,    0,    13, 1, 0, STATUS_OK,        0,  0},
      '{ACT_READ_SLOT,    7,    0,    15, 1, 1, STATUS_BAD_SLOT,  15, 0},
      '{ACT_ERASE_DIR,    7,    8,    0,  1, 1, STATUS_OK,        14, 0},
      '{ACT_ERASE_DIR,    7,    3,    0,  1, 0, STATUS_OK,        0,  0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        op.act    = dir_rows[r].act;
        op.first  = VERTEX_W'(dir_rows[r].first);
        op.second = VERTEX_W'(dir_rows[r].second);
        op.slot   = SLOT_W'(dir_rows[r].slot);
        want.status   = dir_rows[r].status;
        want.degree   = DEGREE_W'(dir_rows[r].degree);
        want.neighbor = VERTEX_W'(dir_rows[r].neighbor);
        send_op(op, dir_rows[r].typed, want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      foreach (vpool[i]) vpool[i] = $urandom_range(0, NUM_VERTICES - 1);
      if (ph % 3 == 0) vpool[0] = 0;
      if (ph % 3 == 1) vpool[1] = NUM_VERTICES - 1;
      quiet = (ph == NUM_PHASES - 1);
      // The reply side holds off while requests keep coming, so the block backs up.
      if (ph == 2) hold_request = 1'b1;
      for (int i = 0; i < PHASE_OPS; i++) send_op(random_op(), 1'b0, want);
      if (ph % 2 == 1) begin
        req_valid <= 1'b0;
        wait_drained();
      end
    end

    req_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/adjslot_pkg.sv
rtl/core/adjacency_slot_store.sv
dv/testbench.sv
